// ===== rtl/axis_step_segment_generator_assert.svh =====
// assertion macros shared by the step segment generator rtl
`ifndef AXIS_STEP_SEGMENT_GENERATOR_ASSERT_SVH
`define AXIS_STEP_SEGMENT_GENERATOR_ASSERT_SVH

// condition checked in the same cycle
`define SSG_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition checked in the next cycle
`define SSG_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/ssg_pkg.sv =====
// shared types and constants of the step segment generator
package ssg_pkg;

	localparam int COORD_BITS_DEF = 32;
	localparam int FIELD_W = 32;
	localparam int DUR_W = 16;
	localparam int STEP_W = 16;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W = 2;
	localparam int S_TDATA_W = 6 * FIELD_W + 2 * DUR_W;
	localparam int M_TDATA_W = 3 * FIELD_W + DUR_W;

	localparam logic [CFG_IDX_W-1:0] REG_STEP_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_Z = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_POINT_DELAY = 2'd3;

	localparam logic [STEP_W-1:0] STEP_RST = 16'd1;
	localparam logic [DUR_W-1:0] POINT_DELAY_RST = 16'd100;

	localparam logic KIND_START = 1'b0;
	localparam logic KIND_ADVANCE = 1'b1;

	typedef enum logic [2:0] {
		PH_IDLE = 3'b001,
		PH_STEP = 3'b010,
		PH_GOAL = 3'b100
	} phase_t;

	typedef struct packed {
		logic load;
		logic step;
		logic to_goal;
	} axis_cmd_t;

	typedef struct packed {
		logic done;
		logic eq;
	} axis_stat_t;

endpackage

// ===== rtl/ssg_axis.sv =====
// one axis: current and goal coordinate, direction and saturating step
module ssg_axis #(
	parameter int COORD_BITS = ssg_pkg::COORD_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  ssg_pkg::axis_cmd_t                  cmd,
	input  logic signed [ssg_pkg::FIELD_W-1:0]  start_c,
	input  logic signed [ssg_pkg::FIELD_W-1:0]  goal_c,
	input  logic        [ssg_pkg::STEP_W-1:0]   step_size,
	output logic        [ssg_pkg::FIELD_W-1:0]  pos_nxt,
	output ssg_pkg::axis_stat_t                 stat
);
	import ssg_pkg::*;

	localparam int EXT_W = (COORD_BITS > FIELD_W) ? COORD_BITS : FIELD_W;
	localparam int WIDE = EXT_W + 2;
	localparam logic signed [WIDE-1:0] CMAX =
		signed'({{(WIDE-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}});
	localparam logic signed [WIDE-1:0] CMIN = ~CMAX;

	logic signed [COORD_BITS-1:0] cur_q, tgt_q;
	logic                         neg_q;

	logic signed [COORD_BITS-1:0] cur_n, tgt_n, st_cl, gl_cl, stepped;
	logic                         neg_n, done_now;
	logic signed [WIDE-1:0]       cur_w, d_w, sum_w, out_w;

	function automatic logic signed [COORD_BITS-1:0] clamp(input logic signed [WIDE-1:0] v);
		logic signed [WIDE-1:0] r;
		r = v;
		if (v > CMAX) r = CMAX;
		if (v < CMIN) r = CMIN;
		return r[COORD_BITS-1:0];
	endfunction

	always_comb begin
		st_cl = clamp(WIDE'(start_c));
		gl_cl = clamp(WIDE'(goal_c));
		cur_w = WIDE'(cur_q);
		d_w = signed'(WIDE'(step_size));
		sum_w = neg_q ? (cur_w - d_w) : (cur_w + d_w);
		stepped = clamp(sum_w);
		done_now = neg_q ? (cur_q <= tgt_q) : (cur_q >= tgt_q);

		cur_n = cur_q;
		tgt_n = tgt_q;
		neg_n = neg_q;
		if (cmd.load) begin
			cur_n = st_cl;
			tgt_n = gl_cl;
			neg_n = st_cl > gl_cl;
		end else if (cmd.step) begin
			if (!done_now) cur_n = stepped;
		end else if (cmd.to_goal) begin
			cur_n = tgt_q;
		end

		stat.done = neg_n ? (cur_n <= tgt_n) : (cur_n >= tgt_n);
		stat.eq = cur_n == tgt_n;
		out_w = WIDE'(cur_n);
		pos_nxt = out_w[FIELD_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= '0;
			tgt_q <= '0;
			neg_q <= 1'b0;
		end else if (en) begin
			cur_q <= cur_n;
			tgt_q <= tgt_n;
			neg_q <= neg_n;
		end
	end

endmodule

// ===== rtl/axis_step_segment_generator.sv =====
// top level of the three-axis step segment generator
// usage: a start word (tuser 0) loads start and goal and returns the start point; every
// advance word (tuser 1) returns the next point, each moving axis stepped by its
// configured size toward the goal and saturated to the coordinate range; once all axes
// are done the goal point follows with its own duration if the last point missed it.
// the last point of a segment has tlast set. an advance with no segment running
// returns nothing. one word is taken every clock cycle while the output side keeps
// taking words: the input register feeds the three axis units, whose add and compare
// settle combinationally into the result register.
`include "axis_step_segment_generator_assert.svh"

module axis_step_segment_generator #(
	parameter int COORD_BITS = ssg_pkg::COORD_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// configuration write port
	input  logic                                 cfg_wr_en,
	input  logic [ssg_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [ssg_pkg::CFG_DATA_W-1:0]       cfg_wdata,
	// input words
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// start_x, start_y, start_z, start_duration, goal_x, goal_y, goal_z, goal_duration
	input  logic [ssg_pkg::S_TDATA_W-1:0]        s_axis_tdata,
	// kind
	input  logic                                 s_axis_tuser,
	// result words
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// pos_x, pos_y, pos_z, duration
	output logic [ssg_pkg::M_TDATA_W-1:0]        m_axis_tdata,
	// final_res
	output logic                                 m_axis_tlast
);
	import ssg_pkg::*;

	// configuration registers
	logic [STEP_W-1:0] step_x_q, step_y_q, step_z_q;
	logic [DUR_W-1:0]  point_delay_q;

	// input register
	logic                      valid_s1;
	logic                      kind_s1;
	logic [S_TDATA_W-1:0]      data_s1;

	// segment state
	phase_t            phase_q, phase_n;
	logic [DUR_W-1:0]  target_dur_q;

	// result register
	logic                  out_valid_q;
	logic [M_TDATA_W-1:0]  out_data_q;
	logic                  out_last_q;

	logic                advance, emit, fin_n;
	logic [DUR_W-1:0]    dur_n;
	axis_cmd_t           cmd;
	axis_stat_t          st_x, st_y, st_z;
	logic [FIELD_W-1:0]  px, py, pz;

	// field slices of the input word
	logic signed [FIELD_W-1:0] start_x, start_y, start_z, goal_x, goal_y, goal_z;
	logic [DUR_W-1:0]          start_dur, goal_dur;

	assign start_x   = signed'(data_s1[FIELD_W-1:0]);
	assign start_y   = signed'(data_s1[2*FIELD_W-1:FIELD_W]);
	assign start_z   = signed'(data_s1[3*FIELD_W-1:2*FIELD_W]);
	assign start_dur = data_s1[3*FIELD_W+DUR_W-1:3*FIELD_W];
	assign goal_x    = signed'(data_s1[4*FIELD_W+DUR_W-1:3*FIELD_W+DUR_W]);
	assign goal_y    = signed'(data_s1[5*FIELD_W+DUR_W-1:4*FIELD_W+DUR_W]);
	assign goal_z    = signed'(data_s1[6*FIELD_W+DUR_W-1:5*FIELD_W+DUR_W]);
	assign goal_dur  = data_s1[S_TDATA_W-1:6*FIELD_W+DUR_W];

	// the stage moves on when the result register is free or being emptied
	assign advance = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tlast  = out_last_q;

	always_comb begin
		cmd.load    = kind_s1 == KIND_START;
		cmd.step    = (kind_s1 == KIND_ADVANCE) && (phase_q == PH_STEP);
		cmd.to_goal = (kind_s1 == KIND_ADVANCE) && (phase_q == PH_GOAL);
	end

	ssg_axis #(.COORD_BITS(COORD_BITS)) u_axis_x (
		.clk(clk), .arst_n(arst_n), .en(advance), .cmd(cmd),
		.start_c(start_x), .goal_c(goal_x), .step_size(step_x_q),
		.pos_nxt(px), .stat(st_x)
	);

	ssg_axis #(.COORD_BITS(COORD_BITS)) u_axis_y (
		.clk(clk), .arst_n(arst_n), .en(advance), .cmd(cmd),
		.start_c(start_y), .goal_c(goal_y), .step_size(step_y_q),
		.pos_nxt(py), .stat(st_y)
	);

	ssg_axis #(.COORD_BITS(COORD_BITS)) u_axis_z (
		.clk(clk), .arst_n(arst_n), .en(advance), .cmd(cmd),
		.start_c(start_z), .goal_c(goal_z), .step_size(step_z_q),
		.pos_nxt(pz), .stat(st_z)
	);

	// sequencing of one segment and the fields of the result word
	always_comb begin
		phase_n = phase_q;
		emit = 1'b0;
		fin_n = 1'b0;
		dur_n = point_delay_q;
		if (cmd.load) begin
			emit = 1'b1;
			dur_n = start_dur;
			// start on the goal: the goal point follows on the next advance
			phase_n = (st_x.eq && st_y.eq && st_z.eq) ? PH_GOAL : PH_STEP;
		end else begin
			unique case (phase_q)
				PH_STEP: begin
					emit = 1'b1;
					if (st_x.done && st_y.done && st_z.done) begin
						if (st_x.eq && st_y.eq && st_z.eq) begin
							// step landed on the goal, no extra goal point
							fin_n = 1'b1;
							phase_n = PH_IDLE;
						end else begin
							phase_n = PH_GOAL;
						end
					end
				end
				PH_GOAL: begin
					emit = 1'b1;
					fin_n = 1'b1;
					dur_n = target_dur_q;
					phase_n = PH_IDLE;
				end
				default: begin
					// advance with no segment running
					phase_n = PH_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_x_q <= STEP_RST;
			step_y_q <= STEP_RST;
			step_z_q <= STEP_RST;
			point_delay_q <= POINT_DELAY_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_STEP_X:      step_x_q <= cfg_wdata;
				REG_STEP_Y:      step_y_q <= cfg_wdata;
				REG_STEP_Z:      step_z_q <= cfg_wdata;
				REG_POINT_DELAY: point_delay_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			kind_s1 <= s_axis_tuser;
			data_s1 <= s_axis_tdata;
		end
	end

	// segment state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			target_dur_q <= '0;
		end else if (advance) begin
			phase_q <= phase_n;
			if (cmd.load) target_dur_q <= goal_dur;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= emit;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			out_data_q <= {dur_n, pz, py, px};
			out_last_q <= fin_n;
		end
	end

	`SSG_ASSERT_NEXT(a_start_not_last, advance && kind_s1 == KIND_START,
		m_axis_tvalid && !m_axis_tlast, "start point must not be marked last")
	`SSG_ASSERT_NEXT(a_goal_is_last,
		advance && kind_s1 == KIND_ADVANCE && phase_q == PH_GOAL,
		m_axis_tvalid && m_axis_tlast, "goal point must be marked last")
	`SSG_ASSERT_NEXT(a_last_ends_segment, advance && emit && fin_n,
		phase_q == PH_IDLE, "last point must end the segment")
	`SSG_ASSERT_NOW(a_stall_blocks_input, valid_s1 && out_valid_q && !m_axis_tready,
		!s_axis_tready, "input taken while stage is blocked")

endmodule

// ===== tb/tb_axis_step_segment_generator.sv =====
// self-checking testbench for the three-axis step segment generator
module tb_axis_step_segment_generator;
	import ssg_pkg::*;

	localparam int COORD_BITS = COORD_BITS_DEF;
	localparam longint COORD_MAX = (longint'(1) << (COORD_BITS - 1)) - 1;
	localparam longint COORD_MIN = -COORD_MAX - 1;

	// input word layout, lowest bit up
	localparam int IN_START = 0;
	localparam int IN_START_DUR = 3 * FIELD_W;
	localparam int IN_GOAL = IN_START_DUR + DUR_W;
	localparam int IN_GOAL_DUR = IN_GOAL + 3 * FIELD_W;
	// result word layout, lowest bit up
	localparam int OUT_DUR = 3 * FIELD_W;

	// quiet cycles after the last expected point, covers the two-stage pipe
	// plus any advance still in flight that yields nothing
	localparam int SETTLE_CYCLES = 8;
	localparam int DRAIN_LIMIT = 4000;
	localparam int PRINT_CAP = 100;

	typedef struct {
		logic [FIELD_W-1:0] pos_x;
		logic [FIELD_W-1:0] pos_y;
		logic [FIELD_W-1:0] pos_z;
		logic [DUR_W-1:0] duration;
		logic last;
	} point_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [S_TDATA_W-1:0] s_axis_tdata = '0;
	logic s_axis_tuser = 1'b0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_axis_tdata;
	logic m_axis_tlast;

	// mirror of the block's registers and segment state
	logic [STEP_W-1:0] step_size [3];
	logic [DUR_W-1:0] point_delay;
	longint cur_pos [3];
	longint goal_pos [3];
	logic [DUR_W-1:0] goal_dur;
	bit run_down [3];
	phase_t seg_phase;

	point_t pending_points [$];
	int mismatches = 0;
	int words_sent = 0;
	int burst_left = 0;
	int ready_cnt = 0;
	int ready_mode = 0;

	axis_step_segment_generator u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		// start_x, start_y, start_z, start_duration, goal_x, goal_y, goal_z, goal_duration
		.s_axis_tdata(s_axis_tdata),
		// kind
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		// pos_x, pos_y, pos_z, duration
		.m_axis_tdata(m_axis_tdata),
		// final_res
		.m_axis_tlast(m_axis_tlast)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// ---------------------------------------------------------------------
	// point predictor
	// ---------------------------------------------------------------------

	function automatic longint clamp_coord(input longint v);
		if (v > COORD_MAX)
			return COORD_MAX;
		if (v < COORD_MIN)
			return COORD_MIN;
		return v;
	endfunction

	// an axis is finished once it reached or passed its goal
	function automatic bit axis_finished(input int a);
		return run_down[a] ? (cur_pos[a] <= goal_pos[a]) : (cur_pos[a] >= goal_pos[a]);
	endfunction

	function automatic bit at_goal();
		return cur_pos[0] == goal_pos[0] && cur_pos[1] == goal_pos[1] &&
			cur_pos[2] == goal_pos[2];
	endfunction

	function automatic point_t make_point(input longint p [3], input logic [DUR_W-1:0] dur,
			input logic last);
		point_t pt;
		pt.pos_x = p[0][FIELD_W-1:0];
		pt.pos_y = p[1][FIELD_W-1:0];
		pt.pos_z = p[2][FIELD_W-1:0];
		pt.duration = dur;
		pt.last = last;
		return pt;
	endfunction

	// next point for one accepted word; returns 0 when the word yields nothing
	function automatic bit predict_point(input logic kind, input logic [S_TDATA_W-1:0] d,
			output point_t pt);
		bit all_fin;
		bit hit;
		if (kind == KIND_START) begin
			for (int a = 0; a < 3; a++) begin
				cur_pos[a] = clamp_coord(longint'($signed(d[IN_START + a * FIELD_W +: FIELD_W])));
				goal_pos[a] = clamp_coord(longint'($signed(d[IN_GOAL + a * FIELD_W +: FIELD_W])));
				run_down[a] = cur_pos[a] > goal_pos[a];
			end
			goal_dur = d[IN_GOAL_DUR +: DUR_W];
			seg_phase = at_goal() ? PH_GOAL : PH_STEP;
			pt = make_point(cur_pos, d[IN_START_DUR +: DUR_W], 1'b0);
			return 1'b1;
		end
		case (seg_phase)
			PH_STEP: begin
				for (int a = 0; a < 3; a++)
					if (!axis_finished(a))
						cur_pos[a] = clamp_coord(run_down[a] ?
							cur_pos[a] - longint'(step_size[a]) :
							cur_pos[a] + longint'(step_size[a]));
				all_fin = axis_finished(0) && axis_finished(1) && axis_finished(2);
				hit = all_fin && at_goal();
				// a stepped point that misses the goal leaves the goal pending
				if (all_fin)
					seg_phase = hit ? PH_IDLE : PH_GOAL;
				pt = make_point(cur_pos, point_delay, hit);
				return 1'b1;
			end
			PH_GOAL: begin
				cur_pos = goal_pos;
				seg_phase = PH_IDLE;
				pt = make_point(goal_pos, goal_dur, 1'b1);
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	// ---------------------------------------------------------------------
	// result checking
	// ---------------------------------------------------------------------

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		if (mismatches < PRINT_CAP)
			$display("mismatch %s: got %h want %h", what, got, want);
		mismatches++;
	endtask

	// handshake values read right after the edge are the ones the edge sampled,
	// since every input is driven by nonblocking assignment
	always @(posedge clk) begin
		point_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_points.size() == 0) begin
				report_mismatch("unexpected word", 64'(m_axis_tdata), 64'd0);
			end else begin
				want = pending_points.pop_front();
				if (m_axis_tdata[0 +: FIELD_W] !== want.pos_x)
					report_mismatch("pos_x", 64'(m_axis_tdata[0 +: FIELD_W]), 64'(want.pos_x));
				if (m_axis_tdata[FIELD_W +: FIELD_W] !== want.pos_y)
					report_mismatch("pos_y", 64'(m_axis_tdata[FIELD_W +: FIELD_W]),
						64'(want.pos_y));
				if (m_axis_tdata[2 * FIELD_W +: FIELD_W] !== want.pos_z)
					report_mismatch("pos_z", 64'(m_axis_tdata[2 * FIELD_W +: FIELD_W]),
						64'(want.pos_z));
				if (m_axis_tdata[OUT_DUR +: DUR_W] !== want.duration)
					report_mismatch("duration", 64'(m_axis_tdata[OUT_DUR +: DUR_W]),
						64'(want.duration));
				if (m_axis_tlast !== want.last)
					report_mismatch("final flag", 64'(m_axis_tlast), 64'(want.last));
			end
		end
	end

	// receiver stalls: the pattern is redrawn periodically, from always
	// ready to coin flips, one in four, and long stalls
	always @(posedge clk) begin
		ready_cnt++;
		if (ready_cnt % 128 == 0)
			ready_mode = $urandom_range(0, 3);
		case (ready_mode)
			0: m_axis_tready <= 1'b1;
			1: m_axis_tready <= 1'($urandom_range(0, 1));
			2: m_axis_tready <= (ready_cnt % 4) == 0;
			default: m_axis_tready <= (ready_cnt % 16) < 3;
		endcase
	end

	// ---------------------------------------------------------------------
	// stimulus helpers
	// ---------------------------------------------------------------------

	// one input word, sent in bursts with random gaps between them
	task automatic send_word(input logic kind, input logic [S_TDATA_W-1:0] payload);
		point_t pt;
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 20);
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= payload;
		s_axis_tuser <= kind;
		do @(posedge clk); while (!s_axis_tready);
		words_sent++;
		// word taken at this edge, so its point can be queued now
		if (predict_point(kind, payload, pt))
			pending_points.insert(pending_points.size(), pt);
	endtask

	// stop sending, wait for every expected point, then let the pipe settle
	task automatic drain();
		int waited;
		waited = 0;
		s_axis_tvalid <= 1'b0;
		while (pending_points.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (pending_points.size() != 0) begin
			report_mismatch("points never delivered", 64'(pending_points.size()), 64'd0);
			pending_points.delete();
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		case (idx)
			REG_STEP_X: step_size[0] = val;
			REG_STEP_Y: step_size[1] = val;
			REG_STEP_Z: step_size[2] = val;
			REG_POINT_DELAY: point_delay = val;
			default: ;
		endcase
	endtask

	// all four registers, written only once the block has gone quiet
	task automatic apply_config(input logic [STEP_W-1:0] sx, input logic [STEP_W-1:0] sy,
			input logic [STEP_W-1:0] sz, input logic [DUR_W-1:0] dly);
		drain();
		write_reg(REG_STEP_X, sx);
		write_reg(REG_STEP_Y, sy);
		write_reg(REG_STEP_Z, sz);
		write_reg(REG_POINT_DELAY, dly);
		cfg_wr_en <= 1'b0;
	endtask

	function automatic logic [S_TDATA_W-1:0] start_word(input longint s [3], input longint g [3],
			input logic [DUR_W-1:0] sdur, input logic [DUR_W-1:0] gdur);
		logic [S_TDATA_W-1:0] d;
		for (int a = 0; a < 3; a++) begin
			d[IN_START + a * FIELD_W +: FIELD_W] = s[a][FIELD_W-1:0];
			d[IN_GOAL + a * FIELD_W +: FIELD_W] = g[a][FIELD_W-1:0];
		end
		d[IN_START_DUR +: DUR_W] = sdur;
		d[IN_GOAL_DUR +: DUR_W] = gdur;
		return d;
	endfunction

	task automatic send_start(input longint s [3], input longint g [3],
			input logic [DUR_W-1:0] sdur, input logic [DUR_W-1:0] gdur);
		send_word(KIND_START, start_word(s, g, sdur, gdur));
	endtask

	// advance words carry random payload, which the block must ignore
	task automatic send_advances(input int n);
		logic [S_TDATA_W-1:0] d;
		repeat (n) begin
			for (int w = 0; w < S_TDATA_W; w += 32)
				d[w +: 32] = $urandom;
			send_word(KIND_ADVANCE, d);
		end
	endtask

	function automatic longint pick_coord();
		case ($urandom_range(0, 7))
			0: return COORD_MAX;
			1: return COORD_MIN;
			default: return longint'($signed($urandom));
		endcase
	endfunction

	// ---------------------------------------------------------------------
	// directed tests
	// ---------------------------------------------------------------------

	// reset values: unit steps and the default point delay
	task automatic test_reset_defaults();
		send_advances(1);              // nothing running yet, no point
		send_start('{0, 0, 0}, '{2, -1, 1}, 16'd7, 16'd9);
		send_advances(3);              // two steps, last one on the goal, then idle
		drain();
	endtask

	task automatic test_start_equals_goal();
		send_start('{5, -5, 5}, '{5, -5, 5}, 16'd11, 16'd22);
		send_advances(2);              // goal point, then nothing
		drain();
	endtask

	// steps that pass the goal, so the goal point follows on its own
	task automatic test_overshoot_goal();
		apply_config(16'd3, 16'd2, 16'hFFFF, 16'd0);
		send_start('{0, 0, 0}, '{10, -4, 1}, 16'h0000, 16'hFFFF);
		send_advances(5);
		drain();
	endtask

	// stepped coordinates pinned at the ends of the coordinate range
	task automatic test_saturation();
		apply_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_start('{COORD_MAX - 10, COORD_MIN + 10, 0}, '{COORD_MAX, COORD_MIN, 0},
			16'd1, 16'd2);
		send_advances(1);              // lands exactly on the goal
		send_start('{COORD_MAX - 10, COORD_MIN + 10, 0},
			'{COORD_MAX - 1, COORD_MIN + 1, 1}, 16'd3, 16'd4);
		send_advances(2);              // clamped past the goal, goal follows
		drain();
	endtask

	// a start word in the middle of a segment replaces it
	task automatic test_restart_busy();
		apply_config(16'd1, 16'd1, 16'd1, 16'd100);
		send_start('{0, 0, 0}, '{100, 100, 100}, 16'd5, 16'd6);
		send_advances(1);
		send_start('{0, 0, 0}, '{-2, -2, -1}, 16'd7, 16'd8);
		send_advances(3);
		drain();
	endtask

	// an axis with no step never arrives, points repeat until a new start
	task automatic test_zero_step();
		apply_config(16'd0, 16'd1, 16'd1, 16'd5);
		send_start('{0, 0, 0}, '{4, 1, 0}, 16'd1, 16'd1);
		send_advances(3);
		send_start('{1, 1, 1}, '{1, 1, 1}, 16'd0, 16'd0);
		send_advances(1);
		drain();
	endtask

	// full-range segments with extreme durations
	task automatic test_field_extremes();
		apply_config(16'd1, 16'd1, 16'd1, 16'd0);
		send_start('{COORD_MAX, COORD_MAX, COORD_MAX}, '{COORD_MIN, COORD_MIN, COORD_MIN},
			16'hFFFF, 16'hFFFF);
		send_advances(1);
		send_start('{COORD_MIN, COORD_MIN, COORD_MIN}, '{COORD_MAX, COORD_MAX, COORD_MAX},
			16'h0000, 16'h0000);
		send_advances(1);
		drain();
	endtask

	// ---------------------------------------------------------------------
	// random segments
	// ---------------------------------------------------------------------

	// mostly segments that finish within a few steps; now and then a far goal
	// that gets cut off by the next start
	task automatic random_segment();
		longint s [3];
		longint g [3];
		longint reach;
		int k;
		int n;
		if ($urandom_range(0, 7) == 0) begin
			for (int a = 0; a < 3; a++) begin
				s[a] = pick_coord();
				g[a] = pick_coord();
			end
			n = $urandom_range(0, 3);
		end else begin
			k = $urandom_range(0, 6);
			for (int a = 0; a < 3; a++) begin
				reach = longint'($urandom_range(0, (k + 1) * int'(step_size[a])));
				s[a] = pick_coord();
				g[a] = clamp_coord($urandom_range(0, 1) ? s[a] + reach : s[a] - reach);
			end
			// fewer advances than needed restart a busy segment, more hit idle
			n = $urandom_range(0, k + 4);
		end
		send_start(s, g, DUR_W'($urandom), DUR_W'($urandom));
		send_advances(n);
	endtask

	task automatic test_random_segments();
		logic [STEP_W-1:0] sx [5] = '{16'd1, 16'hFFFF, 16'd1, 16'd0, 16'd0};
		logic [STEP_W-1:0] sy [5] = '{16'd1, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0};
		logic [STEP_W-1:0] sz [5] = '{16'd1, 16'hFFFF, 16'd300, 16'd0, 16'd0};
		logic [DUR_W-1:0] dly [5] = '{16'd100, 16'hFFFF, 16'd0, 16'd0, 16'd0};
		int target;
		for (int p = 0; p < 5; p++) begin
			// the last two settings are drawn at random
			if (p >= 3)
				apply_config(STEP_W'($urandom_range(1, 65535)), STEP_W'($urandom_range(1, 65535)),
					STEP_W'($urandom_range(1, 65535)), DUR_W'($urandom));
			else
				apply_config(sx[p], sy[p], sz[p], dly[p]);
			target = words_sent + 90;
			while (words_sent < target)
				random_segment();
		end
		drain();
	endtask

	// ---------------------------------------------------------------------
	// sequence
	// ---------------------------------------------------------------------

	initial begin
		step_size = '{STEP_RST, STEP_RST, STEP_RST};
		point_delay = POINT_DELAY_RST;
		cur_pos = '{0, 0, 0};
		goal_pos = '{0, 0, 0};
		goal_dur = '0;
		run_down = '{0, 0, 0};
		seg_phase = PH_IDLE;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_start_equals_goal();
		test_overshoot_goal();
		test_saturation();
		test_restart_busy();
		test_zero_step();
		test_field_extremes();
		test_random_segments();

		if (mismatches == 0)
			$display("** axis_step_segment_generator: PASSED **");
		else
			$display("** axis_step_segment_generator: FAILED **");
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#2000000;
		$display("** axis_step_segment_generator: FAILED **");
		$finish;
	end

endmodule
